// ----- src/v3n_pkg.sv -----
package v3n_pkg;

  localparam int unsigned CompW   = 16;
  localparam int unsigned MagW    = 15;
  localparam int unsigned SqW     = 32;
  localparam int unsigned LenW    = 16;
  localparam int unsigned UnitW   = 16;
  localparam int unsigned UnitSh  = 14;
  localparam int unsigned NumDivW = MagW + 1 + UnitSh;
  localparam int unsigned QuotW   = UnitSh + 1;

  typedef struct packed {
    logic              neg;
    logic [MagW:0]     mag;
  } comp_t;

  typedef struct packed {
    comp_t [2:0]       c;
    logic [SqW-1:0]    sq;
  } vec_t;

endpackage

// ----- src/v3n_sqrt_stage.sv -----
module v3n_sqrt_stage import v3n_pkg::*; #(
  parameter int unsigned StepIdx = 0
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [SqW-1:0] rem_i,
  input  logic [LenW-1:0] root_i,
  output logic [SqW-1:0] rem_o,
  output logic [LenW-1:0] root_o
);

  localparam int unsigned Shift = 2 * (LenW - 1 - StepIdx);

  logic [SqW+1:0]  trial;
  logic [SqW-1:0]  rem_d;
  logic [LenW-1:0] root_d;
  logic [SqW-1:0]  rem_q;
  logic [LenW-1:0] root_q;

  // Restoring square root, one result bit per stage.
  always_comb begin
    trial = ({2'b00, rem_i}) -
            (({16'd0, root_i, 2'b01}) << Shift);
    if (!trial[SqW+1]) begin
      rem_d  = trial[SqW-1:0];
      root_d = {root_i[LenW-2:0], 1'b1};
    end else begin
      rem_d  = rem_i;
      root_d = {root_i[LenW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign rem_o  = rem_q;
  assign root_o = root_q;

endmodule

// ----- src/v3n_div_stage.sv -----
module v3n_div_stage import v3n_pkg::*; #(
  parameter int unsigned StepIdx = 0
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [LenW-1:0]  den_i,
  input  logic [NumDivW-1:0] rem_i,
  input  logic [QuotW-1:0] quo_i,
  output logic [NumDivW-1:0] rem_o,
  output logic [QuotW-1:0] quo_o
);

  localparam int unsigned Shift = QuotW - 1 - StepIdx;

  logic [NumDivW:0]   sub;
  logic [NumDivW-1:0] rem_d;
  logic [QuotW-1:0]   quo_d;
  logic [NumDivW-1:0] rem_q;
  logic [QuotW-1:0]   quo_q;

  // One restoring division step: quotient bit at weight 2^Shift.
  always_comb begin
    sub = {1'b0, rem_i} - ({{(NumDivW + 1 - LenW){1'b0}}, den_i} << Shift);
    if (!sub[NumDivW]) begin
      rem_d = sub[NumDivW-1:0];
      quo_d = quo_i | (QuotW'(1) << Shift);
    end else begin
      rem_d = rem_i;
      quo_d = quo_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign rem_o = rem_q;
  assign quo_o = quo_q;

endmodule

// ----- src/vector3_normalize.sv -----
// The pipe from input beat to output beat has one squaring stage, sixteen
// square-root stages (one root bit each), fifteen shared-step division stages
// (one quotient bit each for all three components in parallel) and a
// sign/output stage.
// Throughput: one beat per cycle; a stall at the output freezes the pipe.
// Reset (rst_ni low, asynchronous) clears the stage valid bits only.
module vector3_normalize import v3n_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [CompW-1:0] comp_x_i,
  input  logic signed [CompW-1:0] comp_y_i,
  input  logic signed [CompW-1:0] comp_z_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [SqW-1:0]          length_squared_o,
  output logic [LenW-1:0]         length_o,
  output logic signed [UnitW-1:0] unit_x_o,
  output logic signed [UnitW-1:0] unit_y_o,
  output logic signed [UnitW-1:0] unit_z_o,
  output logic                    zero_length_o
);

  localparam int unsigned NSq  = LenW;
  localparam int unsigned NDiv = QuotW;
  localparam int unsigned NStg = 1 + NSq + NDiv + 1;

  // The whole pipe advances together; stall holds every stage.
  logic en;
  assign en         = !out_stall_i;
  assign in_stall_o = out_stall_i;

  logic [NStg-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NStg-2:0], in_valid_i};
    end
  end

  // Stage 0: magnitudes and squared sum.
  logic [CompW-1:0] cin [3];
  assign cin[0] = comp_x_i;
  assign cin[1] = comp_y_i;
  assign cin[2] = comp_z_i;

  vec_t v0_d, v0_q;
  always_comb begin
    v0_d.sq = '0;
    for (int i = 0; i < 3; i++) begin
      v0_d.c[i].neg = cin[i][CompW-1];
      v0_d.c[i].mag = cin[i][CompW-1] ? (MagW+1)'(-{1'b1, cin[i]}) : {1'b0, cin[i][MagW-1:0]};
      v0_d.sq = v0_d.sq + SqW'(v0_d.c[i].mag) * SqW'(v0_d.c[i].mag);
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) v0_q <= v0_d;
  end

  // Square-root stages; components ride along.
  logic [SqW-1:0]  srem [NSq+1];
  logic [LenW-1:0] sroot [NSq+1];
  vec_t            sv [NSq+1];
  assign srem[0]  = v0_q.sq;
  assign sroot[0] = '0;
  assign sv[0]    = v0_q;

  for (genvar s = 0; s < NSq; s++) begin : g_sqrt
    v3n_sqrt_stage #(.StepIdx(s)) u_sq (
      .clk_i (clk_i),
      .en_i  (en),
      .rem_i (srem[s]),
      .root_i(sroot[s]),
      .rem_o (srem[s+1]),
      .root_o(sroot[s+1])
    );
    always_ff @(posedge clk_i) begin
      if (en) sv[s+1] <= sv[s];
    end
  end

  // Division stages: (|c| << 14) / length, three lanes.
  logic [NumDivW-1:0] drem [3][NDiv+1];
  logic [QuotW-1:0]   dquo [3][NDiv+1];
  logic [LenW-1:0]    dlen [NDiv+1];
  vec_t               dv   [NDiv+1];
  assign dlen[0] = sroot[NSq];
  assign dv[0]   = sv[NSq];

  for (genvar l = 0; l < 3; l++) begin : g_lane
    assign drem[l][0] = {sv[NSq].c[l].mag, {UnitSh{1'b0}}};
    assign dquo[l][0] = '0;
    for (genvar s = 0; s < NDiv; s++) begin : g_div
      v3n_div_stage #(.StepIdx(s)) u_dv (
        .clk_i(clk_i),
        .en_i (en),
        .den_i(dlen[s]),
        .rem_i(drem[l][s]),
        .quo_i(dquo[l][s]),
        .rem_o(drem[l][s+1]),
        .quo_o(dquo[l][s+1])
      );
    end
  end
  for (genvar s = 0; s < NDiv; s++) begin : g_dctl
    always_ff @(posedge clk_i) begin
      if (en) begin
        dlen[s+1] <= dlen[s];
        dv[s+1]   <= dv[s];
      end
    end
  end

  // Output stage: apply sign, force zero vector to zero units.
  logic [UnitW-1:0] unit_q [3];
  logic [SqW-1:0]   sq_q;
  logic [LenW-1:0]  len_q;
  logic             zero_q;
  logic             zero_d;
  assign zero_d = (dv[NDiv].sq == '0);

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_q   <= dv[NDiv].sq;
      len_q  <= dlen[NDiv];
      zero_q <= zero_d;
      for (int i = 0; i < 3; i++) begin
        if (zero_d) begin
          unit_q[i] <= '0;
        end else if (dv[NDiv].c[i].neg) begin
          unit_q[i] <= -UnitW'(dquo[i][NDiv]);
        end else begin
          unit_q[i] <= UnitW'(dquo[i][NDiv]);
        end
      end
    end
  end

  assign out_valid_o      = vld_q[NStg-1];
  assign length_squared_o = sq_q;
  assign length_o         = len_q;
  assign unit_x_o         = unit_q[0];
  assign unit_y_o         = unit_q[1];
  assign unit_z_o         = unit_q[2];
  assign zero_length_o    = zero_q;

endmodule

// ----- src/v3n_checker.sv -----
module v3n_checker import v3n_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic [SqW-1:0]          length_squared_o,
  input logic [LenW-1:0]         length_o,
  input logic signed [UnitW-1:0] unit_x_o,
  input logic                    zero_length_o
);

  a_zero_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (zero_length_o == (length_squared_o == '0)))
    else $error("zero flag disagrees with squared length");

  a_zero_units: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && zero_length_o) |-> (unit_x_o == '0 && length_o == '0))
    else $error("zero vector gave nonzero outputs");

  a_root_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({32'd0, length_o} * length_o <= {32'd0, length_squared_o}))
    else $error("length exceeds square root");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(length_squared_o)))
    else $error("stalled beat changed");

endmodule

bind vector3_normalize v3n_checker u_v3n_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .length_squared_o(length_squared_o),
  .length_o        (length_o),
  .unit_x_o        (unit_x_o),
  .zero_length_o   (zero_length_o)
);
